FILE: sv/tcl_pkg.sv
// Package for the tone curve lookup block: sizes, function codes, shared types.
// No dependencies; used by tcl_front, tcl_back and the top level.
package tcl_pkg;

  localparam int unsigned MaxPointsDef = 16;
  localparam int unsigned Levels       = 256;
  localparam int unsigned NumChan      = 3;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 5;
  localparam int unsigned QDepth       = 4;

  typedef enum logic [1:0] {
    FuncLoad  = 2'd0,
    FuncBuild = 2'd1,
    FuncPixel = 2'd2,
    FuncNone  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CfgRed   = 2'd0,
    CfgGreen = 2'd1,
    CfgBlue  = 2'd2,
    CfgNone  = 2'd3
  } cfg_idx_e;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    logic       is_build;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } req_t;

  // Back-end build sequencer.
  typedef enum logic [2:0] {
    BkIdle,
    BkFetch,
    BkSeg,
    BkStep,
    BkDone
  } bk_state_e;

endpackage

FILE: sv/tcl_front.sv
// Front part: accepts requests, stores control points, queues build and pixel requests.
// Depends on tcl_pkg.
module tcl_front #(
  parameter int unsigned MaxPoints = tcl_pkg::MaxPointsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic [1:0]           func_i,
  input  logic [1:0]           channel_i,
  input  logic [3:0]           point_index_i,
  input  logic [7:0]           point_x_i,
  input  logic [7:0]           point_y_i,
  input  logic [7:0]           red_in_i,
  input  logic [7:0]           green_in_i,
  input  logic [7:0]           blue_in_i,
  input  logic [7:0]           alpha_in_i,
  input  logic                 pop_i,
  output logic                 q_valid_o,
  output tcl_pkg::req_t        q_head_o,
  output logic                 q_full_o,
  input  logic                 pt_rd_i,
  input  logic [1:0]           pt_ch_i,
  input  logic [$clog2(MaxPoints)-1:0] pt_idx_i,
  output logic [15:0]          pt_data_o
);
  import tcl_pkg::*;

  localparam int unsigned PiW = $clog2(MaxPoints);
  localparam int unsigned QW  = $clog2(QDepth);

  // point memory, one write and one registered read per cycle
  logic [15:0] pt_mem [NumChan*MaxPoints];
  logic        ld_ok;
  logic [$clog2(NumChan*MaxPoints)-1:0] wr_addr, rd_addr;

  assign ld_ok = acc_i && func_e'(func_i) == FuncLoad && channel_i != 2'd3
                 && ({28'd0, point_index_i} < 32'(MaxPoints));
  assign wr_addr = $bits(wr_addr)'(32'(channel_i) * MaxPoints
                                   + 32'(point_index_i[PiW-1:0]));
  assign rd_addr = $bits(rd_addr)'(32'(pt_ch_i) * MaxPoints + 32'(pt_idx_i));

  always_ff @(posedge clk_i) begin
    if (ld_ok) begin
      pt_mem[wr_addr] <= {point_x_i, point_y_i};
    end
    if (pt_rd_i) begin
      pt_data_o <= pt_mem[rd_addr];
    end
  end

  // request queue
  req_t          q_mem [QDepth];
  logic [QW-1:0] wp_q, rp_q;
  logic [QW:0]   cnt_q;
  logic          push;
  logic          bld_q;

  assign push = acc_i && (func_e'(func_i) == FuncBuild || func_e'(func_i) == FuncPixel);

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= '{is_build: func_e'(func_i) == FuncBuild, r: red_in_i,
                       g: green_in_i, b: blue_in_i, a: alpha_in_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
      bld_q <= 1'b0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop_i);
      // a build is pending from its acceptance until the back part retires it
      if (push && func_e'(func_i) == FuncBuild) bld_q <= 1'b1;
      else if (pop_i && q_head_o.is_build) bld_q <= 1'b0;
    end
  end

  assign q_valid_o = cnt_q != '0;
  assign q_head_o  = q_mem[rp_q];
  // no request while a build is pending, so later point loads stay behind it
  assign q_full_o  = cnt_q >= (QW+1)'(QDepth - 1) || bld_q;
endmodule

FILE: sv/tcl_back.sv
// Back part: builds curve tables from control points and looks up pixels.
// Depends on tcl_pkg; reads points from tcl_front.
module tcl_back #(
  parameter int unsigned MaxPoints = tcl_pkg::MaxPointsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [4:0]           cnt_r_i,
  input  logic [4:0]           cnt_g_i,
  input  logic [4:0]           cnt_b_i,
  input  logic                 q_valid_i,
  input  tcl_pkg::req_t        q_head_i,
  output logic                 pop_o,
  output logic                 pt_rd_o,
  output logic [1:0]           pt_ch_o,
  output logic [$clog2(MaxPoints)-1:0] pt_idx_o,
  input  logic [15:0]          pt_data_i,
  output logic                 done_o,
  output logic                 kind_o,
  output logic                 status_o,
  output logic [7:0]           red_out_o,
  output logic [7:0]           green_out_o,
  output logic [7:0]           blue_out_o,
  output logic [7:0]           alpha_out_o
);
  import tcl_pkg::*;

  localparam int unsigned PiW = $clog2(MaxPoints);
  localparam int unsigned CW  = $clog2(MaxPoints + 1);

  // tables, one memory per channel; one valid bit per channel means "built"
  logic [7:0] tab_r [Levels];
  logic [7:0] tab_g [Levels];
  logic [7:0] tab_b [Levels];
  logic [NumChan-1:0] vld_q;

  function automatic logic [CW-1:0] sat(input logic [4:0] c);
    sat = (32'(c) > MaxPoints) ? CW'(MaxPoints) : CW'(c);
  endfunction

  bk_state_e st_q, st_d;
  logic [1:0]    ch_q;
  logic [CW-1:0] k_q;
  logic [CW-1:0] cnt_ch;
  logic          bad_q;
  logic [7:0]    x0_q, y0_q, x1_q, y1_q;
  logic          have_q;
  logic [8:0]    x_q;
  logic [7:0]    fy_q;
  logic [15:0]   pd;
  logic          wr_en;
  logic [7:0]    wr_a, wr_v;
  logic          phase_ext_q;

  assign pd = pt_data_i;
  always_comb begin
    unique case (ch_q)
      2'd0:    cnt_ch = sat(cnt_r_i);
      2'd1:    cnt_ch = sat(cnt_g_i);
      default: cnt_ch = sat(cnt_b_i);
    endcase
  end

  // interpolation: running quotient and remainder of (off*|dy| + dx/2) / dx
  logic [8:0]  dx;
  logic signed [9:0] dy;
  logic [8:0]  ady;
  logic [9:0]  rem_q;
  logic [8:0]  quo_q;
  logic        div_q;
  logic signed [10:0] v;

  assign dx  = {1'b0, x1_q} - {1'b0, x0_q};
  assign dy  = $signed({2'b0, y1_q}) - $signed({2'b0, y0_q});
  assign ady = dy[9] ? 9'(-dy) : 9'(dy);

  always_comb begin
    v = dy[9] ? $signed({3'b0, y0_q}) - $signed({2'b0, quo_q})
              : $signed({3'b0, y0_q}) + $signed({2'b0, quo_q});
  end

  // step conditions
  logic skip, degen, last_pt, div_out, pre_end, seg_end, chan_done;
  assign skip      = bad_q || cnt_ch == '0;
  assign degen     = dx[8] || dx == '0;
  assign last_pt   = (k_q + CW'(1)) >= cnt_ch;
  assign div_out   = div_q && rem_q < {1'b0, dx};
  assign pre_end   = !have_q && x_q[7:0] == x1_q;
  assign seg_end   = have_q && (degen || (div_out && x_q[7:0] == x1_q));
  assign chan_done = skip || (phase_ext_q && x_q[8]);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BkIdle:  if (q_valid_i && q_head_i.is_build) st_d = BkFetch;
      BkFetch: st_d = BkSeg;
      BkSeg:   st_d = BkStep;
      BkStep: begin
        if (chan_done) st_d = (ch_q == 2'(NumChan - 1)) ? BkDone : BkFetch;
        else if (!phase_ext_q && (pre_end || (seg_end && !last_pt))) st_d = BkFetch;
      end
      default: st_d = BkIdle;
    endcase
  end

  logic bad_c;
  assign bad_c = sat(cnt_r_i) == CW'(1) || sat(cnt_g_i) == CW'(1)
              || sat(cnt_b_i) == CW'(1);

  assign pt_rd_o  = 1'b1;
  assign pt_ch_o  = ch_q;
  assign pt_idx_o = k_q[PiW-1:0] ;

  // sequencer: per channel, fill below first x, then each segment, then above last x
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle;
      ch_q <= '0;
      k_q  <= '0;
      bad_q <= 1'b0;
      have_q <= 1'b0;
      x_q <= '0;
      x0_q <= '0; y0_q <= '0; x1_q <= '0; y1_q <= '0; fy_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      div_q <= 1'b0;
      phase_ext_q <= 1'b0;
      vld_q <= '0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        BkIdle: begin
          if (q_valid_i && q_head_i.is_build) begin
            bad_q <= bad_c;
            ch_q <= '0;
            k_q <= '0;
            have_q <= 1'b0;
            phase_ext_q <= 1'b0;
          end
        end
        BkFetch: ;
        BkSeg: begin
          // pt_data holds point k of channel ch
          x0_q <= x1_q; y0_q <= y1_q;
          x1_q <= pd[15:8]; y1_q <= pd[7:0];
          if (!have_q) begin
            fy_q <= pd[7:0];
            x_q <= 9'd0;
          end else begin
            x_q <= {1'b0, x1_q};
          end
          div_q <= 1'b0;
        end
        BkStep: begin
          if (chan_done) begin
            vld_q[ch_q] <= !skip;
            ch_q <= ch_q + 2'd1;
            k_q <= '0;
            have_q <= 1'b0;
            phase_ext_q <= 1'b0;
          end else if (phase_ext_q) begin
            x_q <= x_q + 9'd1;
          end else if (!have_q) begin
            // prefix fill below first x
            if (pre_end) begin
              have_q <= 1'b1;
              k_q <= k_q + CW'(1);
            end else begin
              x_q <= x_q + 9'd1;
            end
          end else if (!degen && !div_q) begin
            // sloped segment setup: remainder starts at half of dx
            rem_q <= {2'b0, dx[8:1]};
            quo_q <= '0;
            div_q <= 1'b1;
          end else if (!degen && !div_out) begin
            rem_q <= rem_q - {1'b0, dx};
            quo_q <= quo_q + 9'd1;
          end else if (seg_end) begin
            if (last_pt) begin
              phase_ext_q <= 1'b1;
              x_q <= {1'b0, x1_q} + 9'd1;
            end else begin
              k_q <= k_q + CW'(1);
            end
          end else begin
            x_q <= x_q + 9'd1;
            rem_q <= rem_q + {1'b0, ady};
          end
        end
        default: ;
      endcase
    end
  end

  // table write selection
  always_comb begin
    wr_en = 1'b0;
    wr_a  = x_q[7:0];
    wr_v  = '0;
    if (st_q == BkStep && !skip) begin
      if (phase_ext_q) begin
        wr_en = !x_q[8];
        wr_v  = y1_q;
      end else if (!have_q) begin
        wr_en = !pre_end;
        wr_v  = fy_q;
      end else if (degen) begin
        wr_en = 1'b1;
        wr_a  = x0_q;
        wr_v  = y1_q;
      end else if (div_out) begin
        wr_en = 1'b1;
        wr_v  = v[10] ? 8'd0 : (v > 11'sd255 ? 8'd255 : v[7:0]);
      end
    end
  end

  // pixel path: registered table reads, one result per cycle while no build is in progress
  logic px;
  assign px = st_q == BkIdle && q_valid_i && !q_head_i.is_build;
  assign pop_o = px || st_q == BkDone;

  logic [7:0] rr, gr, br;
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      unique case (ch_q)
        2'd0:    tab_r[wr_a] <= wr_v;
        2'd1:    tab_g[wr_a] <= wr_v;
        default: tab_b[wr_a] <= wr_v;
      endcase
    end
    rr <= tab_r[q_head_i.r];
    gr <= tab_g[q_head_i.g];
    br <= tab_b[q_head_i.b];
  end

  logic       px_q, bd_q, vr_q, vg_q, vb_q;
  logic [7:0] ir_q, ig_q, ib_q, ia_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= 1'b0;
      bd_q <= 1'b0;
    end else begin
      px_q <= px;
      bd_q <= st_q == BkDone;
    end
  end
  always_ff @(posedge clk_i) begin
    ir_q <= q_head_i.r; ig_q <= q_head_i.g; ib_q <= q_head_i.b; ia_q <= q_head_i.a;
    vr_q <= vld_q[0];
    vg_q <= vld_q[1];
    vb_q <= vld_q[2];
  end

  assign done_o      = px_q || bd_q;
  assign kind_o      = px_q;
  assign status_o    = bd_q && bad_q;
  assign red_out_o   = px_q ? (vr_q ? rr : ir_q) : 8'd0;
  assign green_out_o = px_q ? (vg_q ? gr : ig_q) : 8'd0;
  assign blue_out_o  = px_q ? (vb_q ? br : ib_q) : 8'd0;
  assign alpha_out_o = px_q ? ia_q : 8'd0;
endmodule

FILE: sv/tone_curve_lut_core.sv
// Top level of the tone curve lookup block: config registers, front and back parts.
// Depends on tcl_pkg, tcl_front, tcl_back.
//
//  channel | handshake               | payload
//  request | start & !busy           | func, channel, point_*, *_in
//  result  | done_o (one cycle)      | kind, status, *_out
//  config  | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Pixels: one per cycle while no build is in progress, via the request queue and the
// registered table read. Build: per channel a fetch of each point, a write of each
// table entry, and per sloped segment a setup step plus one step per unit of |dy|.
// busy is high from a build's acceptance until its result, and when the queue holds 3.
// Reset clears the config and control registers and the per-channel table valid bits (tables read as identity).
// The receiver cannot stall.
module tone_curve_lut_core #(
  parameter int unsigned MaxPoints = tcl_pkg::MaxPointsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   func_i,
  input  logic [1:0]                   channel_i,
  input  logic [3:0]                   point_index_i,
  input  logic [7:0]                   point_x_i,
  input  logic [7:0]                   point_y_i,
  input  logic [7:0]                   red_in_i,
  input  logic [7:0]                   green_in_i,
  input  logic [7:0]                   blue_in_i,
  input  logic [7:0]                   alpha_in_i,
  input  logic                         cfg_we_i,
  input  logic [tcl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcl_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         done_o,
  output logic                         kind_o,
  output logic                         status_o,
  output logic [7:0]                   red_out_o,
  output logic [7:0]                   green_out_o,
  output logic [7:0]                   blue_out_o,
  output logic [7:0]                   alpha_out_o
);
  import tcl_pkg::*;

  logic [4:0] cnt_q [NumChan];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) cnt_q[c] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRed:   cnt_q[0] <= cfg_data_i;
        CfgGreen: cnt_q[1] <= cfg_data_i;
        CfgBlue:  cnt_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic acc, pop, qv, qf, prd;
  req_t head;
  logic [1:0] pch;
  logic [$clog2(MaxPoints)-1:0] pidx;
  logic [15:0] pdat;

  assign acc  = start && !busy;
  assign busy = qf;

  tcl_front #(.MaxPoints(MaxPoints)) u_front (
    .clk_i, .rst_ni, .acc_i(acc), .func_i, .channel_i, .point_index_i, .point_x_i,
    .point_y_i, .red_in_i, .green_in_i, .blue_in_i, .alpha_in_i, .pop_i(pop),
    .q_valid_o(qv), .q_head_o(head), .q_full_o(qf), .pt_rd_i(prd), .pt_ch_i(pch),
    .pt_idx_i(pidx), .pt_data_o(pdat)
  );

  tcl_back #(.MaxPoints(MaxPoints)) u_back (
    .clk_i, .rst_ni, .cnt_r_i(cnt_q[0]), .cnt_g_i(cnt_q[1]), .cnt_b_i(cnt_q[2]),
    .q_valid_i(qv), .q_head_i(head), .pop_o(pop), .pt_rd_o(prd), .pt_ch_o(pch),
    .pt_idx_o(pidx), .pt_data_i(pdat), .done_o, .kind_o, .status_o, .red_out_o,
    .green_out_o, .blue_out_o, .alpha_out_o
  );
endmodule

FILE: sv/tcl_checker.sv
// Port-level checks for the tone curve lookup block, bound to the top level.
// Depends on tone_curve_lut_core ports only.
module tcl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       done_o,
  input logic       kind_o,
  input logic       status_o,
  input logic [7:0] alpha_out_o,
  input logic [7:0] red_out_o
);
  // pixel results never carry a build status
  a_px_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && kind_o |-> !status_o) else $error("pixel with status");
  // build results carry zero pixel data
  a_bd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !kind_o |-> alpha_out_o == 8'd0 && red_out_o == 8'd0)
    else $error("build result with data");
  // two build results never come back to back
  a_bd_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !kind_o |=> !(done_o && !kind_o)) else $error("build twice");
endmodule

bind tone_curve_lut_core tcl_checker u_chk (.*);
